/* design/bim_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bim_pkg: shared types and constants of the best IoU box matcher
// Coordinate width, derived arithmetic widths, register indexes and the
// sequencer state type.
// ----------------------------------------------------------------------------
package bim_pkg;

    localparam int COORD_BITS = 12;
    localparam int EDGE_W     = COORD_BITS + 1;
    localparam int AREA_W     = 2 * COORD_BITS;
    localparam int UNI_W      = AREA_W + 1;
    localparam int PROD_W     = 2 * UNI_W;
    localparam int REM_W      = UNI_W + 1;
    localparam int FRAC_BITS  = 16;
    localparam int OV_W       = FRAC_BITS + 1;
    localparam int DIV_STEPS  = FRAC_BITS + 1;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W  = 2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_REF_X = 2'd0;
    localparam t_cfg_idx CFG_REF_Y = 2'd1;
    localparam t_cfg_idx CFG_REF_W = 2'd2;
    localparam t_cfg_idx CFG_REF_H = 2'd3;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MI   = 9'b000000010,
        S_MC   = 9'b000000100,
        S_MR   = 9'b000001000,
        S_MA   = 9'b000010000,
        S_MB   = 9'b000100000,
        S_CMP  = 9'b001000000,
        S_DIV  = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

endpackage : bim_pkg
`default_nettype wire

/* design/best_iou_box_matcher.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// best_iou_box_matcher: keeps the candidate box with the highest IoU
// Scores each candidate against the reference box with one shared
// multiplier, keeps the strict best by cross-multiplied compare, and on the
// last item emits found, the best box and its overlap in Q1.16.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------
//  input    | i_valid / o_stall         | i_cand_x/y/w/h, i_has_box, i_last
//  output   | o_valid / i_stall         | o_found, o_best_x/y/w/h, o_best_overlap
//  config   | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
//  An item holds o_stall high through five products on the shared
//  25x25 multiplier and one cross-product compare. An item marked last adds
//  17 divide steps (one quotient bit each) and one output load step.
//  The output register holds a result while i_stall is high; the next item
//  is accepted meanwhile, and a further last item waits in its load step.
//  Synchronous active-low reset clears configuration, best state and valid.
//
module best_iou_box_matcher
    import bim_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire [COORD_BITS-1:0] i_cand_x,
    input  wire [COORD_BITS-1:0] i_cand_y,
    input  wire [COORD_BITS-1:0] i_cand_w,
    input  wire [COORD_BITS-1:0] i_cand_h,
    input  wire                  i_has_box,
    input  wire                  i_last,
    output logic                 o_valid,
    input  wire                  i_stall,
    output logic                 o_found,
    output logic [COORD_BITS-1:0] o_best_x,
    output logic [COORD_BITS-1:0] o_best_y,
    output logic [COORD_BITS-1:0] o_best_w,
    output logic [COORD_BITS-1:0] o_best_h,
    output logic [OV_W-1:0]       o_best_overlap,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [COORD_BITS-1:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [COORD_BITS-1:0] r_ref_x, r_ref_y, r_ref_w, r_ref_h;

    logic [COORD_BITS-1:0] r_cx, r_cy, r_cw, r_ch;
    logic                  r_has, r_last, r_ovl;
    logic [COORD_BITS-1:0] r_ix, r_iy;

    logic [PROD_W-1:0] r_prod, r_p1;
    logic [AREA_W-1:0] r_inter, r_acc;
    logic [UNI_W-1:0]  r_uni;

    logic                  r_have_best;
    logic [AREA_W-1:0]     r_best_inter;
    logic [UNI_W-1:0]      r_best_uni;
    logic [COORD_BITS-1:0] r_best_x, r_best_y, r_best_w, r_best_h;

    logic [REM_W-1:0] r_rem;
    logic [OV_W-1:0]  r_quo;
    logic [CNT_W-1:0] r_cnt;

    logic                  r_o_valid, r_o_found;
    logic [COORD_BITS-1:0] r_o_x, r_o_y, r_o_w, r_o_h;
    logic [OV_W-1:0]       r_o_ov;

    // overlap test and intersection sides, taken from the ports at accept
    logic [EDGE_W-1:0] cr, cb, rr, rb, min_r, max_l, min_b, max_t, ix_full, iy_full;
    logic              ovl, accept, out_free, wins;
    logic [UNI_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [REM_W-1:0]  div_t, div_d;
    logic              div_ge;

    assign accept   = i_valid && r_state == S_IDLE;
    assign out_free = !r_o_valid || !i_stall;

    always_comb begin
        cr = EDGE_W'(i_cand_x) + EDGE_W'(i_cand_w);
        cb = EDGE_W'(i_cand_y) + EDGE_W'(i_cand_h);
        rr = EDGE_W'(r_ref_x) + EDGE_W'(r_ref_w);
        rb = EDGE_W'(r_ref_y) + EDGE_W'(r_ref_h);
        ovl = !(EDGE_W'(i_cand_x) > rr || EDGE_W'(i_cand_y) > rb ||
                cr < EDGE_W'(r_ref_x) || cb < EDGE_W'(r_ref_y));
        min_r = (cr < rr) ? cr : rr;
        max_l = (i_cand_x > r_ref_x) ? EDGE_W'(i_cand_x) : EDGE_W'(r_ref_x);
        min_b = (cb < rb) ? cb : rb;
        max_t = (i_cand_y > r_ref_y) ? EDGE_W'(i_cand_y) : EDGE_W'(r_ref_y);
        ix_full = min_r - max_l;
        iy_full = min_b - max_t;
    end

    // shared multiplier
    always_comb begin
        unique case (r_state)
            S_MI: begin
                mul_a = UNI_W'(r_ix);
                mul_b = UNI_W'(r_iy);
            end
            S_MC: begin
                mul_a = UNI_W'(r_cw);
                mul_b = UNI_W'(r_ch);
            end
            S_MR: begin
                mul_a = UNI_W'(r_ref_w);
                mul_b = UNI_W'(r_ref_h);
            end
            S_MA: begin
                mul_a = UNI_W'(r_inter);
                mul_b = r_best_uni;
            end
            S_MB: begin
                mul_a = UNI_W'(r_best_inter);
                mul_b = r_uni;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    assign wins = r_has && r_ovl && r_inter != '0 && r_uni != '0 &&
                  (!r_have_best || r_p1 > r_prod);

    // restoring divide step: one quotient bit per cycle
    always_comb begin
        div_t  = (r_cnt == '0) ? r_rem : {r_rem[REM_W-2:0], 1'b0};
        div_d  = REM_W'(r_best_uni);
        div_ge = div_t >= div_d;
    end

    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = accept ? S_MI : S_IDLE;
            S_MI:    n_state = S_MC;
            S_MC:    n_state = S_MR;
            S_MR:    n_state = S_MA;
            S_MA:    n_state = S_MB;
            S_MB:    n_state = S_CMP;
            S_CMP:   n_state = r_last ? S_DIV : S_IDLE;
            S_DIV:   n_state = (r_cnt == CNT_W'(DIV_STEPS - 1)) ? S_OUT : S_DIV;
            S_OUT:   n_state = out_free ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ref_x     <= '0;
            r_ref_y     <= '0;
            r_ref_w     <= '0;
            r_ref_h     <= '0;
            r_have_best <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_REF_X: r_ref_x <= i_cfg_data;
                    CFG_REF_Y: r_ref_y <= i_cfg_data;
                    CFG_REF_W: r_ref_w <= i_cfg_data;
                    CFG_REF_H: r_ref_h <= i_cfg_data;
                    default:   r_ref_x <= r_ref_x;
                endcase
            end
            if (r_state == S_CMP && wins) begin
                r_have_best <= 1'b1;
            end
            if (r_state == S_OUT && out_free) begin
                r_o_valid   <= 1'b1;
                r_have_best <= 1'b0;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cx   <= i_cand_x;
            r_cy   <= i_cand_y;
            r_cw   <= i_cand_w;
            r_ch   <= i_cand_h;
            r_has  <= i_has_box;
            r_last <= i_last;
            r_ovl  <= ovl;
            r_ix   <= ix_full[COORD_BITS-1:0];
            r_iy   <= iy_full[COORD_BITS-1:0];
        end
        r_prod <= mul_p;
        unique case (r_state)
            S_MC: r_inter <= r_prod[AREA_W-1:0];
            S_MR: r_acc   <= r_prod[AREA_W-1:0];
            S_MA: r_uni   <= UNI_W'(r_acc) + UNI_W'(r_prod) - UNI_W'(r_inter);
            S_MB: r_p1    <= r_prod;
            S_CMP: begin
                if (wins) begin
                    r_best_inter <= r_inter;
                    r_best_uni   <= r_uni;
                    r_best_x     <= r_cx;
                    r_best_y     <= r_cy;
                    r_best_w     <= r_cw;
                    r_best_h     <= r_ch;
                    r_rem        <= REM_W'(r_inter);
                end else begin
                    r_rem <= REM_W'(r_best_inter);
                end
                r_cnt <= '0;
                r_quo <= '0;
            end
            S_DIV: begin
                r_rem <= div_ge ? div_t - div_d : div_t;
                r_quo <= {r_quo[OV_W-2:0], div_ge};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            S_OUT: begin
                if (out_free) begin
                    r_o_found <= r_have_best;
                    r_o_x     <= r_have_best ? r_best_x : '0;
                    r_o_y     <= r_have_best ? r_best_y : '0;
                    r_o_w     <= r_have_best ? r_best_w : '0;
                    r_o_h     <= r_have_best ? r_best_h : '0;
                    r_o_ov    <= r_have_best ? r_quo : '0;
                end
            end
            default: r_cnt <= r_cnt;
        endcase
    end

    assign o_stall        = r_state != S_IDLE;
    assign o_valid        = r_o_valid;
    assign o_found        = r_o_found;
    assign o_best_x       = r_o_x;
    assign o_best_y       = r_o_y;
    assign o_best_w       = r_o_w;
    assign o_best_h       = r_o_h;
    assign o_best_overlap = r_o_ov;

`ifndef NO_ASSERTIONS
    a_nofound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !r_o_found |-> r_o_ov == '0 && r_o_x == '0 && r_o_w == '0)
        else $error("result without a match carries a nonzero box or overlap");

    a_best_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have_best && !(r_state == S_CMP) |->
            r_best_inter != '0 && r_best_uni >= UNI_W'(r_best_inter))
        else $error("best score has zero intersection or union below it");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_cnt <= CNT_W'(DIV_STEPS - 1))
        else $error("divide step count overran");

    a_out_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT && out_free |=> r_o_valid && !r_have_best && r_state == S_IDLE)
        else $error("result load did not clear the set state");
`endif

endmodule : best_iou_box_matcher
`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the best IoU box matcher
// Walks a directed table of register writes and candidate items, then runs
// random candidate sets against several reference boxes under four idling
// modes. A local scoring model predicts each result that the table does not
// give; results are compared field by field in order.
// ----------------------------------------------------------------------------
module tb;
    import bim_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 40;
    localparam int SEG_ITEMS   = 180;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
        logic                  has_box;
        logic                  last;
    } cand_t;

    typedef struct packed {
        logic                  found;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
        logic [OV_W-1:0]       overlap;
    } match_t;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        t_cfg_idx              idx;
        logic [COORD_BITS-1:0] data;
        cand_t                 cand;
        logic                  known;
        match_t                res;
    } plan_row_t;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [COORD_BITS-1:0] i_cand_x;
    logic [COORD_BITS-1:0] i_cand_y;
    logic [COORD_BITS-1:0] i_cand_w;
    logic [COORD_BITS-1:0] i_cand_h;
    logic                  i_has_box;
    logic                  i_last;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_found;
    logic [COORD_BITS-1:0] o_best_x;
    logic [COORD_BITS-1:0] o_best_y;
    logic [COORD_BITS-1:0] o_best_w;
    logic [COORD_BITS-1:0] o_best_h;
    logic [OV_W-1:0]       o_best_overlap;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_idx;
    logic [COORD_BITS-1:0] i_cfg_data;

    // reference box and running best, as the block should hold them
    longint unsigned tgt_x, tgt_y, tgt_w, tgt_h;
    longint unsigned top_inter, top_union;
    cand_t           top_box;
    bit              top_seen;

    match_t      pending_matches[$];
    plan_row_t   plan[$];
    idle_mode_t  idle_mode = IDLE_NONE;
    int          mismatches = 0;
    int          items_sent = 0;
    int unsigned cycle_count = 0;

    best_iou_box_matcher dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cand_x       (i_cand_x),
        .i_cand_y       (i_cand_y),
        .i_cand_w       (i_cand_w),
        .i_cand_h       (i_cand_h),
        .i_has_box      (i_has_box),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_found        (o_found),
        .o_best_x       (o_best_x),
        .o_best_y       (o_best_y),
        .o_best_w       (o_best_w),
        .o_best_h       (o_best_h),
        .o_best_overlap (o_best_overlap),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("best_iou_box_matcher regression: fail");
            $finish;
        end
    end

    // scores one candidate, returns the set result when the item is last
    function automatic void score_candidate(input cand_t c, output bit emits,
                                            output match_t r);
        longint unsigned cx, cy, cw, ch, cr, cb, rr, rb;
        longint unsigned ix, iy, inter, uni, ov;
        bit wins;
        cx = c.x;
        cy = c.y;
        cw = c.w;
        ch = c.h;
        r = '0;
        emits = c.last;
        if (c.has_box) begin
            cr = cx + cw;
            cb = cy + ch;
            rr = tgt_x + tgt_w;
            rb = tgt_y + tgt_h;
            if (!(cx > rr || cy > rb || cr < tgt_x || cb < tgt_y)) begin
                ix = (cr < rr ? cr : rr) - (cx > tgt_x ? cx : tgt_x);
                iy = (cb < rb ? cb : rb) - (cy > tgt_y ? cy : tgt_y);
                inter = ix * iy;
                uni = cw * ch + tgt_w * tgt_h - inter;
                if (inter == 0 || uni == 0)
                    wins = 1'b0;
                else if (!top_seen)
                    wins = 1'b1;
                else
                    wins = (inter * top_union) > (top_inter * uni);
                if (wins) begin
                    top_inter = inter;
                    top_union = uni;
                    top_box   = c;
                    top_seen  = 1'b1;
                end
            end
        end
        if (c.last) begin
            if (top_seen && top_union != 0) begin
                ov = (top_inter << 16) / top_union;
                if (ov > 65536)
                    ov = 65536;
                r.found   = 1'b1;
                r.x       = top_box.x;
                r.y       = top_box.y;
                r.w       = top_box.w;
                r.h       = top_box.h;
                r.overlap = ov[OV_W-1:0];
            end
            top_inter = 0;
            top_union = 0;
            top_box   = '0;
            top_seen  = 1'b0;
        end
    endfunction

    function automatic bit sender_idles();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(99, 0) < 78;
            IDLE_BOTH:   return $urandom_range(99, 0) < 31;
            default:     return 1'b0;
        endcase
    endfunction

    always @(negedge i_clk) begin
        case (idle_mode)
            IDLE_RECEIVER: i_stall <= ($urandom_range(99, 0) < 78);
            IDLE_BOTH:     i_stall <= ($urandom_range(99, 0) < 31);
            default:       i_stall <= 1'b0;
        endcase
    end

    always @(posedge i_clk) begin
        match_t got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_found, o_best_x, o_best_y, o_best_w, o_best_h, o_best_overlap};
            if (pending_matches.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: found=%0d box=(%0d,%0d,%0d,%0d) ov=%0d",
                             got.found, got.x, got.y, got.w, got.h, got.overlap);
                mismatches++;
            end else begin
                want = pending_matches.pop_front();
                if (got.found !== want.found || got.x !== want.x || got.y !== want.y ||
                    got.w !== want.w || got.h !== want.h ||
                    got.overlap !== want.overlap) begin
                    if (mismatches < 10)
                        $display({"mismatch: expected found=%0d box=(%0d,%0d,%0d,%0d) ",
                                  "ov=%0d, got found=%0d box=(%0d,%0d,%0d,%0d) ov=%0d"},
                                 want.found, want.x, want.y, want.w, want.h, want.overlap,
                                 got.found, got.x, got.y, got.w, got.h, got.overlap);
                    mismatches++;
                end
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input cand_t c, input logic known, input match_t known_res);
        match_t r;
        bit emits;
        bit done;
        while (sender_idles()) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_cand_x  = c.x;
        i_cand_y  = c.y;
        i_cand_w  = c.w;
        i_cand_h  = c.h;
        i_has_box = c.has_box;
        i_last    = c.last;
        done = 1'b0;
        while (!done) begin
            @(posedge i_clk);
            done = !o_stall;
            @(negedge i_clk);
        end
        items_sent++;
        score_candidate(c, emits, r);
        if (emits)
            pending_matches.push_back(known ? known_res : r);
    endtask

    // waits for the block to drain, then writes one register
    task automatic write_reg(input t_cfg_idx idx, input logic [COORD_BITS-1:0] data);
        i_valid = 1'b0;
        while (pending_matches.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_REF_X: tgt_x = data;
            CFG_REF_Y: tgt_y = data;
            CFG_REF_W: tgt_w = data;
            CFG_REF_H: tgt_h = data;
        endcase
    endtask

    task automatic load_ref(input int x, input int y, input int w, input int h);
        write_reg(CFG_REF_X, COORD_BITS'(x));
        write_reg(CFG_REF_Y, COORD_BITS'(y));
        write_reg(CFG_REF_W, COORD_BITS'(w));
        write_reg(CFG_REF_H, COORD_BITS'(h));
    endtask

    function automatic void plan_cfg(input t_cfg_idx idx, input logic [COORD_BITS-1:0] data);
        plan_row_t r;
        r      = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = data;
        plan.push_back(r);
    endfunction

    function automatic void plan_item(input logic [COORD_BITS-1:0] x, y, w, h,
                                      input logic has, last);
        plan_row_t r;
        r      = '0;
        r.kind = ROW_ITEM;
        r.cand = {x, y, w, h, has, last};
        plan.push_back(r);
    endfunction

    function automatic void plan_known(input logic [COORD_BITS-1:0] x, y, w, h,
                                       input logic has, last, found,
                                       input logic [COORD_BITS-1:0] bx, by, bw, bh,
                                       input logic [OV_W-1:0] ov);
        plan_row_t r;
        r       = '0;
        r.kind  = ROW_ITEM;
        r.cand  = {x, y, w, h, has, last};
        r.known = 1'b1;
        r.res   = {found, bx, by, bw, bh, ov};
        plan.push_back(r);
    endfunction

    function automatic logic [COORD_BITS-1:0] pick_near(input int base, input int size);
        int lo, hi;
        lo = base - size / 2 - 8;
        hi = base + size + 8;
        if (lo < 0)
            lo = 0;
        if (hi > 4095)
            hi = 4095;
        if ($urandom_range(7, 0) == 0)
            return $urandom_range(1, 0) ? 12'hFFF : 12'h000;
        return COORD_BITS'($urandom_range(hi, lo));
    endfunction

    // one candidate set: mostly boxes around the reference, some noise,
    // repeats for ties and empty markers
    task automatic send_random_set();
        int    len;
        int    kind;
        cand_t c, prev;
        len  = $urandom_range(6, 1);
        prev = '0;
        for (int k = 0; k < len; k++) begin
            kind = $urandom_range(9, 0);
            if (kind == 0) begin
                c = cand_t'($urandom);
                c.has_box = 1'b0;
            end else if (kind == 1) begin
                c = {COORD_BITS'($urandom), COORD_BITS'($urandom),
                     COORD_BITS'($urandom), COORD_BITS'($urandom), 2'b10};
            end else if (kind == 2 && k > 0 && prev.has_box) begin
                c = prev;
            end else begin
                c.x = pick_near(int'(tgt_x), int'(tgt_w));
                c.y = pick_near(int'(tgt_y), int'(tgt_h));
                c.w = pick_near(int'(tgt_w) / 4, int'(tgt_w));
                c.h = pick_near(int'(tgt_h) / 4, int'(tgt_h));
                c.has_box = 1'b1;
            end
            c.last = (k == len - 1);
            send_item(c, 1'b0, '0);
            prev = c;
        end
    endtask

    initial begin
        int target;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_cand_x   = '0;
        i_cand_y   = '0;
        i_cand_w   = '0;
        i_cand_h   = '0;
        i_has_box  = 1'b0;
        i_last     = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_REF_X;
        i_cfg_data = '0;
        tgt_x = 0;
        tgt_y = 0;
        tgt_w = 0;
        tgt_h = 0;
        top_inter = 0;
        top_union = 0;
        top_box   = '0;
        top_seen  = 1'b0;

        // reference box all zero after reset
        plan_known(0, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0);
        plan_known(4095, 4095, 4095, 4095, 0, 1, 0, 0, 0, 0, 0, 0);
        plan_cfg(CFG_REF_X, 100);
        plan_cfg(CFG_REF_Y, 100);
        plan_cfg(CFG_REF_W, 200);
        plan_cfg(CFG_REF_H, 200);
        plan_known(100, 100, 200, 200, 1, 1, 1, 100, 100, 200, 200, 65536);
        plan_known(301, 100, 10, 10, 1, 1, 0, 0, 0, 0, 0, 0);
        plan_known(300, 100, 10, 10, 1, 1, 0, 0, 0, 0, 0, 0);
        // equal scores keep the first box; set closes on an empty marker
        plan_item(150, 150, 100, 100, 1, 0);
        plan_item(0, 0, 4095, 4095, 1, 0);
        plan_item(150, 150, 100, 100, 1, 0);
        plan_item(200, 200, 100, 100, 1, 0);
        plan_item(4095, 4095, 4095, 4095, 0, 1);
        plan_item(120, 120, 180, 180, 1, 0);
        plan_item(100, 100, 200, 199, 1, 1);
        plan_known(4095, 4095, 4095, 4095, 1, 1, 0, 0, 0, 0, 0, 0);
        plan_known(150, 150, 0, 50, 1, 1, 0, 0, 0, 0, 0, 0);
        plan_cfg(CFG_REF_X, 4095);
        plan_cfg(CFG_REF_Y, 4095);
        plan_cfg(CFG_REF_W, 4095);
        plan_cfg(CFG_REF_H, 4095);
        plan_known(4095, 4095, 4095, 4095, 1, 1, 1, 4095, 4095, 4095, 4095, 65536);
        plan_item(0, 0, 4095, 4095, 1, 0);
        plan_item(4000, 4000, 200, 300, 1, 1);
        plan_cfg(CFG_REF_X, 0);
        plan_cfg(CFG_REF_Y, 0);
        plan_item(0, 0, 1, 1, 1, 0);
        plan_known(0, 0, 4095, 4095, 1, 1, 1, 0, 0, 4095, 4095, 65536);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (plan[n]) begin
            if (plan[n].kind == ROW_CFG)
                write_reg(plan[n].idx, plan[n].data);
            else
                send_item(plan[n].cand, plan[n].known, plan[n].res);
        end

        for (int seg = 0; seg < 8; seg++) begin
            case (seg)
                1: load_ref(0, 0, 4095, 4095);
                3: load_ref(4095, 4095, 4095, 4095);
                5: load_ref($urandom_range(4095, 0), $urandom_range(4095, 0), 0,
                            $urandom_range(4095, 0));
                6: load_ref($urandom_range(4095, 0), $urandom_range(4095, 0),
                            $urandom_range(16, 1), $urandom_range(16, 1));
                default: load_ref($urandom_range(4095, 0), $urandom_range(4095, 0),
                                  $urandom_range(1500, 0), $urandom_range(1500, 0));
            endcase
            idle_mode = idle_mode_t'(seg % 4);
            target = items_sent + SEG_ITEMS;
            while (items_sent < target)
                send_random_set();
        end

        i_valid = 1'b0;
        while (pending_matches.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0)
            $display("best_iou_box_matcher regression: pass");
        else
            $display("best_iou_box_matcher regression: fail");
        $finish;
    end

endmodule
